### hw/rtl/tfd_pkg.sv
package tfd_pkg;

  localparam int unsigned POS_W       = 34;
  localparam int unsigned LEN_W       = 32;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned CFG_IDX_W   = 4;
  localparam int unsigned HDR_POS_W   = 4;
  localparam int unsigned OUT_DEPTH_DEF = 4;

  localparam logic [POS_W-1:0] HEADER_BYTES = POS_W'(16);
  localparam logic [POS_W-1:0] POS_MAX      = {POS_W{1'b1}};

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(65535);

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_META = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DATA = CFG_IDX_W'(1);

  localparam logic [KIND_W-1:0] KIND_HEADER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_META   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DATA   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RESERVED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_META_BIG = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DATA_BIG = 3'd4;
  localparam logic [STATUS_W-1:0] ST_MISMATCH = 3'd5;
  localparam logic [STATUS_W-1:0] ST_BAD_TYPE = 3'd6;

  localparam logic [BYTE_W-1:0] TYPE_LO_MIN = 8'd1;
  localparam logic [BYTE_W-1:0] TYPE_LO_MAX = 8'd21;
  localparam logic [BYTE_W-1:0] TYPE_HI_MIN = 8'd30;
  localparam logic [BYTE_W-1:0] TYPE_HI_MAX = 8'd32;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [BYTE_W-1:0]   frame_type;
    logic [BYTE_W-1:0]   frame_flags;
    logic [LEN_W-1:0]    stream_number;
    logic [LEN_W-1:0]    meta_length;
    logic [LEN_W-1:0]    data_length;
    logic [BYTE_W-1:0]   payload_byte;
    logic [STATUS_W-1:0] status;
    logic                last_result;
  } result_t;

  function automatic logic type_known(input logic [BYTE_W-1:0] t);
    return (t >= TYPE_LO_MIN && t <= TYPE_LO_MAX) || (t >= TYPE_HI_MIN && t <= TYPE_HI_MAX);
  endfunction

endpackage

### hw/rtl/tfd_ifs.sv
interface tfd_byte_if;
  import tfd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] frame_byte;
  logic              end_of_buffer;

  modport source (output valid, frame_byte, end_of_buffer, input ready);
  modport sink   (input valid, frame_byte, end_of_buffer, output ready);
endinterface

interface tfd_result_if;
  import tfd_pkg::*;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [BYTE_W-1:0]   frame_type;
  logic [BYTE_W-1:0]   frame_flags;
  logic [LEN_W-1:0]    stream_number;
  logic [LEN_W-1:0]    meta_length;
  logic [LEN_W-1:0]    data_length;
  logic [BYTE_W-1:0]   payload_byte;
  logic [STATUS_W-1:0] status;
  logic                last_result;

  modport source (output valid, kind, frame_type, frame_flags, stream_number, meta_length,
                  data_length, payload_byte, status, last_result, input ready);
  modport sink   (input valid, kind, frame_type, frame_flags, stream_number, meta_length,
                  data_length, payload_byte, status, last_result, output ready);
endinterface

interface tfd_cfg_if;
  import tfd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [LEN_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/tunnel_frame_deframer_unit.sv
// a result is written to the result queue as its byte is accepted and is offered
// from the queue head; throughput: one byte per cycle; a byte causing two results
// queues the second behind the first in the OUT_DEPTH-entry result queue, which
// takes a byte only while two entries are free
// reset (synchronous, rst_n low): frame state cleared, both length limits 65535,
// result queue empty
module tunnel_frame_deframer_unit #(
  parameter int unsigned OUT_DEPTH = tfd_pkg::OUT_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  tfd_byte_if.sink       in_bus,
  tfd_result_if.source   out_bus,
  tfd_cfg_if.sink        cfg_bus
);
  import tfd_pkg::*;

  localparam int unsigned PTR_W = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(OUT_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(OUT_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_ROOM = CNT_W'(OUT_DEPTH - 2);

  // limit registers
  logic [LEN_W-1:0] max_meta_r;
  logic [LEN_W-1:0] max_data_r;

  // frame state
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [BYTE_W-1:0] type_r, type_nxt;
  logic [BYTE_W-1:0] flags_r, flags_nxt;
  logic [LEN_W-1:0]  stream_r, stream_nxt;
  logic [LEN_W-1:0]  meta_r, meta_nxt;
  logic [LEN_W-1:0]  data_r, data_nxt;
  logic              res_bad_r, res_bad_nxt;
  logic              type_bad_r, type_bad_nxt;

  // result queue
  result_t          queue_r [OUT_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic              in_fire, out_fire, cfg_fire;
  logic [BYTE_W-1:0] b;
  logic              hdr;
  logic [HDR_POS_W-1:0] hpos;
  logic [POS_W-1:0]  q;
  logic [POS_W-1:0]  pos_inc;
  logic [POS_W-1:0]  expect_len;
  logic [POS_W-1:0]  payload_len;
  logic              len_err;
  logic              emit_a;
  result_t           res_a, res_st, push0, push1;
  logic [1:0]        n_push;
  logic [PTR_W-1:0]  wr_ptr_p1;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  assign in_fire  = in_bus.valid && in_bus.ready;
  assign out_fire = out_bus.valid && out_bus.ready;
  assign cfg_fire = cfg_bus.valid && cfg_bus.ready;

  assign in_bus.ready  = (cnt_r <= CNT_ROOM);
  assign cfg_bus.ready = 1'b1;

  assign b    = in_bus.frame_byte;
  assign hdr  = (pos_r < HEADER_BYTES);
  assign hpos = pos_r[HDR_POS_W-1:0];
  assign q    = pos_r - HEADER_BYTES;

  always_comb begin
    type_nxt     = type_r;
    flags_nxt    = flags_r;
    stream_nxt   = stream_r;
    meta_nxt     = meta_r;
    data_nxt     = data_r;
    res_bad_nxt  = res_bad_r;
    type_bad_nxt = type_bad_r;
    emit_a       = 1'b0;
    res_a        = '0;
    res_st       = '0;
    payload_len  = POS_W'(meta_r) + POS_W'(data_r);
    len_err      = (meta_r > max_meta_r) || (data_r > max_data_r);

    if (hdr) begin
      case (hpos) inside
        4'd0: begin
          type_nxt     = b;
          type_bad_nxt = !type_known(b);
        end
        4'd1: flags_nxt = b;
        4'd2, 4'd3: begin
          if (b != '0) begin
            res_bad_nxt = 1'b1;
          end
        end
        [4'd4:4'd7]:  stream_nxt = {stream_r[LEN_W-BYTE_W-1:0], b};
        [4'd8:4'd11]: meta_nxt   = {meta_r[LEN_W-BYTE_W-1:0], b};
        default:      data_nxt   = {data_r[LEN_W-BYTE_W-1:0], b};
      endcase
      if (hpos == HDR_POS_W'(15)) begin
        emit_a              = 1'b1;
        res_a.kind          = KIND_HEADER;
        res_a.frame_type    = type_nxt;
        res_a.frame_flags   = flags_nxt;
        res_a.stream_number = stream_nxt;
        res_a.meta_length   = meta_nxt;
        res_a.data_length   = data_nxt;
      end
    end else if (!len_err && q < payload_len) begin
      emit_a             = 1'b1;
      res_a.kind         = (q < POS_W'(meta_r)) ? KIND_META : KIND_DATA;
      res_a.payload_byte = b;
    end

    pos_inc    = (pos_r == POS_MAX) ? pos_r : pos_r + POS_W'(1);
    expect_len = HEADER_BYTES + POS_W'(meta_nxt) + POS_W'(data_nxt);

    res_st.kind        = KIND_STATUS;
    res_st.last_result = 1'b1;
    if (pos_inc < HEADER_BYTES) begin
      res_st.status = ST_SHORT;
    end else if (res_bad_nxt) begin
      res_st.status = ST_RESERVED;
    end else if (meta_nxt > max_meta_r) begin
      res_st.status = ST_META_BIG;
    end else if (data_nxt > max_data_r) begin
      res_st.status = ST_DATA_BIG;
    end else if (pos_inc != expect_len) begin
      res_st.status = ST_MISMATCH;
    end else if (type_bad_nxt) begin
      res_st.status = ST_BAD_TYPE;
    end else begin
      res_st.status = ST_OK;
    end

    res_a.last_result = !in_bus.end_of_buffer;
    pos_nxt = pos_inc;

    if (in_bus.end_of_buffer) begin
      pos_nxt      = '0;
      type_nxt     = '0;
      flags_nxt    = '0;
      stream_nxt   = '0;
      meta_nxt     = '0;
      data_nxt     = '0;
      res_bad_nxt  = 1'b0;
      type_bad_nxt = 1'b0;
    end
  end

  // queue bookkeeping
  always_comb begin
    push0 = emit_a ? res_a : res_st;
    push1 = res_st;
    if (!in_fire) begin
      n_push = 2'd0;
    end else begin
      n_push = 2'(emit_a) + 2'(in_bus.end_of_buffer);
    end
    wr_ptr_p1  = ptr_inc(wr_ptr_r);
    wr_ptr_nxt = wr_ptr_r;
    if (n_push == 2'd1) begin
      wr_ptr_nxt = wr_ptr_p1;
    end else if (n_push == 2'd2) begin
      wr_ptr_nxt = ptr_inc(wr_ptr_p1);
    end
    rd_ptr_nxt = out_fire ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(n_push) - CNT_W'(out_fire);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_meta_r <= MAX_LEN_RESET;
      max_data_r <= MAX_LEN_RESET;
    end else if (cfg_fire) begin
      if (cfg_bus.index == CFG_MAX_META) begin
        max_meta_r <= cfg_bus.data;
      end else if (cfg_bus.index == CFG_MAX_DATA) begin
        max_data_r <= cfg_bus.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      type_r     <= '0;
      flags_r    <= '0;
      stream_r   <= '0;
      meta_r     <= '0;
      data_r     <= '0;
      res_bad_r  <= 1'b0;
      type_bad_r <= 1'b0;
    end else if (in_fire) begin
      pos_r      <= pos_nxt;
      type_r     <= type_nxt;
      flags_r    <= flags_nxt;
      stream_r   <= stream_nxt;
      meta_r     <= meta_nxt;
      data_r     <= data_nxt;
      res_bad_r  <= res_bad_nxt;
      type_bad_r <= type_bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      queue_r[wr_ptr_r] <= push0;
    end
    if (n_push == 2'd2) begin
      queue_r[wr_ptr_p1] <= push1;
    end
  end

  assign out_bus.valid         = (cnt_r != '0);
  assign out_bus.kind          = queue_r[rd_ptr_r].kind;
  assign out_bus.frame_type    = queue_r[rd_ptr_r].frame_type;
  assign out_bus.frame_flags   = queue_r[rd_ptr_r].frame_flags;
  assign out_bus.stream_number = queue_r[rd_ptr_r].stream_number;
  assign out_bus.meta_length   = queue_r[rd_ptr_r].meta_length;
  assign out_bus.data_length   = queue_r[rd_ptr_r].data_length;
  assign out_bus.payload_byte  = queue_r[rd_ptr_r].payload_byte;
  assign out_bus.status        = queue_r[rd_ptr_r].status;
  assign out_bus.last_result   = queue_r[rd_ptr_r].last_result;

endmodule

### hw/rtl/tfd_checker.sv
module tfd_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [tfd_pkg::KIND_W-1:0]     kind,
  input logic [tfd_pkg::BYTE_W-1:0]     frame_type,
  input logic [tfd_pkg::LEN_W-1:0]      stream_number,
  input logic [tfd_pkg::STATUS_W-1:0]   status,
  input logic                           last_result
);
  import tfd_pkg::*;

  // results held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind == KIND_STATUS |-> last_result)
    else $error("end status not marked as final result");

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind != KIND_STATUS |-> status == ST_OK)
    else $error("status set on a non-status result");

  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (kind == KIND_META || kind == KIND_DATA) |->
      frame_type == '0 && stream_number == '0)
    else $error("header fields leak into payload result");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

endmodule

bind tunnel_frame_deframer_unit tfd_checker u_tfd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_bus.valid),
  .out_ready     (out_bus.ready),
  .kind          (out_bus.kind),
  .frame_type    (out_bus.frame_type),
  .stream_number (out_bus.stream_number),
  .status        (out_bus.status),
  .last_result   (out_bus.last_result)
);

### verif/tb_top.sv
module tb_top;
  import tfd_pkg::*;

  localparam int PHASES      = 5;
  localparam int PHASE_ITEMS = 180;
  localparam int HOLD_CYCLES = 200;
  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              eob;
  } frame_byte_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  tfd_byte_if   in_bus ();
  tfd_result_if out_bus ();
  tfd_cfg_if    cfg_bus ();

  tunnel_frame_deframer_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  frame_byte_t frame_bytes_q[$];
  result_t     deframed_q[$];
  frame_byte_t drv_item;

  int   err_count     = 0;
  int   quiet_cycles  = 0;
  int   src_idle_pct  = 0;
  int   snk_stall_pct = 0;
  int   hold_asked    = 0;
  int   hold_seen     = 0;
  int   hold_left     = 0;
  int   phase_items   = 0;
  logic in_taken      = 1'b0;

  // frame state of the predictor
  logic [POS_W-1:0]  rx_pos;
  logic [BYTE_W-1:0] rx_type;
  logic [BYTE_W-1:0] rx_flags;
  logic [LEN_W-1:0]  rx_stream;
  logic [LEN_W-1:0]  rx_meta_len;
  logic [LEN_W-1:0]  rx_data_len;
  logic              rx_rsv_bad;
  logic              rx_type_bad;
  logic [LEN_W-1:0]  lim_meta;
  logic [LEN_W-1:0]  lim_data;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    err_count++;
  endtask

  function automatic logic known_type(input logic [BYTE_W-1:0] t);
    return ((t >= TYPE_LO_MIN) && (t <= TYPE_LO_MAX)) ||
           ((t >= TYPE_HI_MIN) && (t <= TYPE_HI_MAX));
  endfunction

  task automatic clear_frame_state();
    rx_pos      = '0;
    rx_type     = '0;
    rx_flags    = '0;
    rx_stream   = '0;
    rx_meta_len = '0;
    rx_data_len = '0;
    rx_rsv_bad  = 1'b0;
    rx_type_bad = 1'b0;
  endtask

  task automatic deframe_byte(input logic [BYTE_W-1:0] b, input logic eob);
    result_t          res [2];
    int               n;
    int               i;
    logic [POS_W-1:0] q;
    logic [POS_W-1:0] span;
    logic [POS_W-1:0] want_len;
    logic [STATUS_W-1:0] st;
    n = 0;
    if (rx_pos < HEADER_BYTES) begin
      case (rx_pos[HDR_POS_W-1:0])
        4'd0: begin
          rx_type     = b;
          rx_type_bad = !known_type(b);
        end
        4'd1: rx_flags = b;
        4'd2, 4'd3: if (b != '0) rx_rsv_bad = 1'b1;
        4'd4, 4'd5, 4'd6, 4'd7: rx_stream = {rx_stream[LEN_W-9:0], b};
        4'd8, 4'd9, 4'd10, 4'd11: rx_meta_len = {rx_meta_len[LEN_W-9:0], b};
        default: rx_data_len = {rx_data_len[LEN_W-9:0], b};
      endcase
      if (rx_pos == HEADER_BYTES - 1) begin
        res[n]               = '0;
        res[n].kind          = KIND_HEADER;
        res[n].frame_type    = rx_type;
        res[n].frame_flags   = rx_flags;
        res[n].stream_number = rx_stream;
        res[n].meta_length   = rx_meta_len;
        res[n].data_length   = rx_data_len;
        n++;
      end
    end else begin
      q    = rx_pos - HEADER_BYTES;
      span = {2'b00, rx_meta_len} + {2'b00, rx_data_len};
      if (rx_meta_len <= lim_meta && rx_data_len <= lim_data && q < span) begin
        res[n]              = '0;
        res[n].kind         = (q < {2'b00, rx_meta_len}) ? KIND_META : KIND_DATA;
        res[n].payload_byte = b;
        n++;
      end
    end
    if (rx_pos != POS_MAX) rx_pos = rx_pos + POS_W'(1);
    if (eob) begin
      want_len = HEADER_BYTES + {2'b00, rx_meta_len} + {2'b00, rx_data_len};
      if (rx_pos < HEADER_BYTES) st = ST_SHORT;
      else if (rx_rsv_bad) st = ST_RESERVED;
      else if (rx_meta_len > lim_meta) st = ST_META_BIG;
      else if (rx_data_len > lim_data) st = ST_DATA_BIG;
      else if (rx_pos != want_len) st = ST_MISMATCH;
      else if (rx_type_bad) st = ST_BAD_TYPE;
      else st = ST_OK;
      res[n]        = '0;
      res[n].kind   = KIND_STATUS;
      res[n].status = st;
      n++;
      clear_frame_state();
    end
    if (n > 0) res[n-1].last_result = 1'b1;
    for (i = 0; i < n; i++) deframed_q.push_back(res[i]);
  endtask

  task automatic cmp_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h exp %0h", name, got, want));
  endtask

  task automatic check_deframed();
    result_t want;
    if (deframed_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result kind %0d", out_bus.kind));
    end else begin
      want = deframed_q.pop_front();
      cmp_field("kind", 32'(out_bus.kind), 32'(want.kind));
      cmp_field("frame_type", 32'(out_bus.frame_type), 32'(want.frame_type));
      cmp_field("frame_flags", 32'(out_bus.frame_flags), 32'(want.frame_flags));
      cmp_field("stream_number", out_bus.stream_number, want.stream_number);
      cmp_field("meta_length", out_bus.meta_length, want.meta_length);
      cmp_field("data_length", out_bus.data_length, want.data_length);
      cmp_field("payload_byte", 32'(out_bus.payload_byte), 32'(want.payload_byte));
      cmp_field("status", 32'(out_bus.status), 32'(want.status));
      cmp_field("last_result", 32'(out_bus.last_result), 32'(want.last_result));
    end
  endtask

  // monitor: transactions are sampled at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken     <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      in_taken <= in_bus.valid && in_bus.ready;
      if (in_bus.valid && in_bus.ready) deframe_byte(in_bus.frame_byte, in_bus.end_of_buffer);
      if (out_bus.valid && out_bus.ready) check_deframed();
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // byte driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || in_taken) begin
      if (frame_bytes_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        drv_item = frame_bytes_q.pop_front();
        in_bus.valid         <= 1'b1;
        in_bus.frame_byte    <= drv_item.value;
        in_bus.end_of_buffer <= drv_item.eob;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // result sink, with a long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (hold_seen != hold_asked) begin
      hold_seen     <= hold_asked;
      hold_left     <= HOLD_CYCLES;
      out_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] value);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    if (idx == CFG_MAX_META) lim_meta = value;
    else if (idx == CFG_MAX_DATA) lim_data = value;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic queue_frame(input logic [BYTE_W-1:0] ftype, input logic [BYTE_W-1:0] fflags,
                             input logic [BYTE_W-1:0] r2, input logic [BYTE_W-1:0] r3,
                             input logic [LEN_W-1:0] sid, input logic [LEN_W-1:0] mlen,
                             input logic [LEN_W-1:0] dlen, input int nbytes);
    logic [BYTE_W-1:0] hdr [16];
    frame_byte_t       fb;
    int                i;
    hdr = '{ftype, fflags, r2, r3, sid[31:24], sid[23:16], sid[15:8], sid[7:0],
            mlen[31:24], mlen[23:16], mlen[15:8], mlen[7:0],
            dlen[31:24], dlen[23:16], dlen[15:8], dlen[7:0]};
    for (i = 0; i < nbytes; i++) begin
      fb.value = (i < 16) ? hdr[i] : BYTE_W'($urandom_range(0, 255));
      fb.eob   = (i == nbytes - 1);
      frame_bytes_q.push_back(fb);
    end
    phase_items += nbytes;
  endtask

  task automatic queue_random_frame();
    int                pick;
    int                t;
    int                m_i;
    int                d_i;
    int                n;
    logic [BYTE_W-1:0] ftype;
    logic [BYTE_W-1:0] fflags;
    logic [BYTE_W-1:0] r2;
    logic [BYTE_W-1:0] r3;
    logic [LEN_W-1:0]  sid;
    logic [LEN_W-1:0]  m;
    logic [LEN_W-1:0]  d;
    pick   = $urandom_range(0, 99);
    t      = $urandom_range(0, 23);
    ftype  = (t < 21) ? TYPE_LO_MIN + BYTE_W'(t) : TYPE_HI_MIN + BYTE_W'(t - 21);
    fflags = BYTE_W'($urandom);
    r2     = '0;
    r3     = '0;
    sid    = $urandom;
    m_i    = $urandom_range(0, (lim_meta < 6) ? int'(lim_meta) : 6);
    d_i    = $urandom_range(0, (lim_data < 8) ? int'(lim_data) : 8);
    m      = m_i;
    d      = d_i;
    n      = 16 + m_i + d_i;
    if (pick < 60) begin
      // well-formed, nothing to change
    end else if (pick < 67) begin
      n += $urandom_range(1, 3);
    end else if (pick < 73) begin
      if (m_i + d_i > 0) n = 16 + $urandom_range(0, m_i + d_i - 1);
      else n = $urandom_range(1, 15);
    end else if (pick < 78) begin
      n = $urandom_range(1, 15);
    end else if (pick < 83) begin
      r2 = ($urandom_range(0, 1) != 0) ? BYTE_W'($urandom_range(1, 255)) : '0;
      r3 = (r2 == '0) ? BYTE_W'($urandom_range(1, 255)) : BYTE_W'($urandom);
    end else if (pick < 88) begin
      if ($urandom_range(0, 1) != 0) m = $urandom;
      else m = (lim_meta > 32'hFFFF_FFF0) ? '1 : lim_meta + 1 + $urandom_range(0, 3);
      n = 16 + $urandom_range(0, 6);
    end else if (pick < 93) begin
      if ($urandom_range(0, 1) != 0) d = $urandom;
      else d = (lim_data > 32'hFFFF_FFF0) ? '1 : lim_data + 1 + $urandom_range(0, 3);
      n = 16 + $urandom_range(0, 6);
    end else if (pick < 97) begin
      case ($urandom_range(0, 2))
        0: ftype = '0;
        1: ftype = BYTE_W'($urandom_range(22, 29));
        default: ftype = BYTE_W'($urandom_range(33, 255));
      endcase
    end else begin
      // noise
      ftype = BYTE_W'($urandom);
      r2    = BYTE_W'($urandom);
      r3    = BYTE_W'($urandom);
      m     = $urandom;
      d     = $urandom;
      n     = $urandom_range(1, 30);
    end
    queue_frame(ftype, fflags, r2, r3, sid, m, d, n);
  endtask

  task automatic wait_drained();
    while (frame_bytes_q.size() != 0 || in_bus.valid || deframed_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    int ph;
    in_bus.valid         = 1'b0;
    in_bus.frame_byte    = '0;
    in_bus.end_of_buffer = 1'b0;
    out_bus.ready        = 1'b0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.index        = '0;
    cfg_bus.data         = '0;
    clear_frame_state();
    lim_meta = MAX_LEN_RESET;
    lim_data = MAX_LEN_RESET;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        1: begin
          write_limit(CFG_MAX_META, '0);
          write_limit(CFG_MAX_DATA, '0);
        end
        2: begin
          write_limit(CFG_MAX_META, '1);
          write_limit(CFG_MAX_DATA, '1);
        end
        3: begin
          write_limit(CFG_MAX_META, $urandom_range(1, 8));
          write_limit(CFG_MAX_DATA, $urandom_range(1, 12));
        end
        4: begin
          write_limit(CFG_MAX_META, 32'd7);
          write_limit(CFG_MAX_DATA, MAX_LEN_RESET);
        end
        default: ;
      endcase
      case (ph)
        1: begin
          src_idle_pct  = 54;
          snk_stall_pct = 0;
        end
        2: begin
          src_idle_pct  = 0;
          snk_stall_pct = 54;
        end
        3: begin
          src_idle_pct  = 27;
          snk_stall_pct = 27;
        end
        default: begin
          src_idle_pct  = 0;
          snk_stall_pct = 0;
        end
      endcase
      phase_items = 0;
      if (ph == 0) begin
        // short frames of 1, 2 and 4 bytes, header ending on the last byte
        queue_frame(8'hFF, 8'h00, 8'h00, 8'h00, '0, '0, '0, 1);
        queue_frame(8'h00, 8'h00, 8'h00, 8'h00, '0, '0, '0, 2);
        queue_frame(TYPE_HI_MAX, 8'hFF, 8'h00, 8'h00, '1, '0, '0, 16);
        queue_frame(8'h00, 8'hFF, 8'hFF, 8'h80, '0, '0, '0, 4);
      end
      while (phase_items < PHASE_ITEMS) queue_random_frame();
      if (ph == 0) hold_asked++;
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (deframed_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", deframed_q.size()));
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/tfd_pkg.sv
hw/rtl/tfd_ifs.sv
hw/rtl/tunnel_frame_deframer_unit.sv
hw/rtl/tfd_checker.sv
verif/tb_top.sv
